// ===== rtl/core/acfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive cumulative frequency model: shared definitions
// Opcodes, controller states and the control groups that travel between the
// controller and the count cells.
// ----------------------------------------------------------------------------
package acfm_pkg;

	// Width of the freeze limit register
	localparam int LIMIT_WIDTH = 16;
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd16383;

	// Operation codes carried on s_tuser
	typedef enum logic [1:0] {
		OP_ENCODE   = 2'd0,
		OP_DECODE   = 2'd1,
		OP_REINIT   = 2'd2,
		OP_RESERVED = 2'd3
	} opcode_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} fsm_state_t;

	// Command broadcast to every cell
	typedef struct packed {
		logic decode;   // search by scale instead of symbol index
		logic adapt;    // increment entries above the symbol
		logic reinit;   // restore entry i to i
	} cell_cmd_t;

	// Control part of the sweep token handed from cell to cell
	typedef struct packed {
		logic act;      // token present in this stage
		logic prev_gt;  // scale was below the count of the cell below
	} tok_ctl_t;

endpackage

// ===== rtl/core/acfm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Count cell
// Holds one cumulative count. When the sweep token passes, it checks whether
// it closes the requested symbol's range, captures low/high counts into the
// token, increments itself if it lies above the symbol, and forwards the
// token together with its own count to the next cell.
// ----------------------------------------------------------------------------
module acfm_cell #(
	parameter int IDX         = 0,
	parameter int COUNT_WIDTH = 16,
	parameter int SYM_WIDTH   = 9
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  acfm_pkg::cell_cmd_t    cmd,
	input  logic [SYM_WIDTH-1:0]   sym,
	input  logic [COUNT_WIDTH-1:0] scale,
	input  acfm_pkg::tok_ctl_t     tok_in,
	input  logic [COUNT_WIDTH-1:0] prev_in,
	input  logic [COUNT_WIDTH-1:0] lo_in,
	input  logic [COUNT_WIDTH-1:0] hi_in,
	input  logic [SYM_WIDTH-1:0]   sym_in,
	output acfm_pkg::tok_ctl_t     tok_out,
	output logic [COUNT_WIDTH-1:0] prev_out,
	output logic [COUNT_WIDTH-1:0] lo_out,
	output logic [COUNT_WIDTH-1:0] hi_out,
	output logic [SYM_WIDTH-1:0]   sym_out,
	output logic [COUNT_WIDTH-1:0] count
);
	import acfm_pkg::*;

	// Reset value: own index, saturated to the largest count
	localparam longint unsigned CMAX   = (64'd1 << COUNT_WIDTH) - 64'd1;
	localparam longint unsigned INIT_L = (longint'(IDX) > CMAX) ? CMAX : longint'(IDX);
	localparam logic [COUNT_WIDTH-1:0] INIT   = COUNT_WIDTH'(INIT_L);
	// Symbol whose range this cell closes, and own index as a symbol value
	localparam logic [SYM_WIDTH-1:0]   MY_SYM = SYM_WIDTH'(IDX - 1);
	localparam logic [SYM_WIDTH-1:0]   IDX_S  = SYM_WIDTH'(IDX);

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   act_q;
	logic                   prev_gt_q;
	logic [COUNT_WIDTH-1:0] prev_q, lo_q, hi_q;
	logic [SYM_WIDTH-1:0]   sym_q;
	logic                   gt, match, inc;

	// Local match and increment decisions
	always_comb begin
		gt    = scale < count_q;
		match = tok_in.act && (cmd.decode ? (gt && !tok_in.prev_gt)
		                                  : ((IDX != 0) && (sym == MY_SYM)));
		inc   = tok_in.act && cmd.adapt && (count_q != '1) &&
		        (cmd.decode ? gt : (sym < IDX_S));
	end

	// Count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= INIT;
		end else if (cmd.reinit) begin
			count_q <= INIT;
		end else if (inc) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Token presence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= tok_in.act;
		end
	end

	// Token payload, pre-update values only
	always_ff @(posedge clk) begin
		prev_gt_q <= gt;
		prev_q    <= count_q;
		lo_q      <= match ? prev_in : lo_in;
		hi_q      <= match ? count_q : hi_in;
		sym_q     <= match ? MY_SYM : sym_in;
	end

	assign tok_out  = '{act: act_q, prev_gt: prev_gt_q};
	assign prev_out = prev_q;
	assign lo_out   = lo_q;
	assign hi_out   = hi_q;
	assign sym_out  = sym_q;
	assign count    = count_q;

endmodule

// ===== rtl/core/adaptive_cumulative_frequency_model_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive cumulative frequency model unit
// Cumulative count table for an arithmetic coder, kept in a chain of count
// cells, with encode, decode and reinitialize operations.
// ----------------------------------------------------------------------------
// One item is handled at a time. Encode and decode run a token up the chain
// of SYMBOLS+1 count cells, one cell per cycle, which finds the symbol's
// range and applies the adaptive increment on the way. Reinitialize, the
// reserved opcode and requests that are not found skip the chain and go
// straight to the finish state. A result waits in an output register, so the
// next transaction is accepted while the previous result is still pending.
// The freeze limit is written over the cfg channel, which is always ready;
// write it only while the unit is idle.
// ----------------------------------------------------------------------------
module adaptive_cumulative_frequency_model_unit #(
	parameter int SYMBOLS     = 257,
	parameter int COUNT_WIDTH = 16,
	localparam int SYM_WIDTH  = $clog2(SYMBOLS + 1),
	localparam int IN_DW      = ((SYM_WIDTH + COUNT_WIDTH + 7) / 8) * 8,
	localparam int OUT_DW     = ((SYM_WIDTH + 3 * COUNT_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel: freeze limit
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [acfm_pkg::LIMIT_WIDTH-1:0]  cfg_data,
	// Request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_DW-1:0]                  s_tdata,   // symbol, scale
	input  acfm_pkg::opcode_t                 s_tuser,   // opcode
	// Result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_DW-1:0]                 m_tdata,   // symbol_out, low_count,
	                                                     // high_count, total_count
	output logic [1:0]                        m_tuser    // not_found, is_frozen
);
	import acfm_pkg::*;

	localparam int TABLE_LEN = SYMBOLS + 1;
	localparam int CMP_W     = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

	// Controller state
	fsm_state_t state_q, state_d;
	logic [LIMIT_WIDTH-1:0] limit_q;
	logic                   frozen_q;
	logic                   start_q;
	opcode_t                op_q;
	logic [SYM_WIDTH-1:0]   sym_q;
	logic [COUNT_WIDTH-1:0] scale_q;
	logic                   adapt_q, nf_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] res_lo_q, res_hi_q;
	logic [SYM_WIDTH-1:0]   res_sym_q;
	logic                   m_tvalid_q;
	logic [OUT_DW-1:0]      m_tdata_q;
	logic [1:0]             m_tuser_q;

	// Request decode
	logic [SYM_WIDTH-1:0]   in_sym;
	logic [COUNT_WIDTH-1:0] in_scale;
	logic                   accept, in_nf, go_sweep, in_serve;
	logic                   out_load;
	logic                   frozen_d;
	logic [SYM_WIDTH-1:0]   o_sym;
	logic [COUNT_WIDTH-1:0] o_lo, o_hi, o_total;
	logic                   o_nf;

	// Chain wiring
	cell_cmd_t              cmd;
	tok_ctl_t               tok_ch  [0:TABLE_LEN];
	logic [COUNT_WIDTH-1:0] prev_ch [0:TABLE_LEN];
	logic [COUNT_WIDTH-1:0] lo_ch   [0:TABLE_LEN];
	logic [COUNT_WIDTH-1:0] hi_ch   [0:TABLE_LEN];
	logic [SYM_WIDTH-1:0]   sym_ch  [0:TABLE_LEN];
	logic [COUNT_WIDTH-1:0] total_w;

	assign in_sym   = s_tdata[SYM_WIDTH-1:0];
	assign in_scale = s_tdata[SYM_WIDTH+COUNT_WIDTH-1:SYM_WIDTH];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Not-found detection and sweep decision at acceptance
	always_comb begin
		in_serve = (s_tuser == OP_ENCODE) || (s_tuser == OP_DECODE);
		in_nf    = ((s_tuser == OP_ENCODE) && (in_sym >= SYM_WIDTH'(SYMBOLS))) ||
		           ((s_tuser == OP_DECODE) && (in_scale >= total_w));
		go_sweep = in_serve && !in_nf;
	end

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and result load
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = go_sweep ? ST_SWEEP : ST_FINISH;
				end
			end
			ST_SWEEP: begin
				if (tok_ch[TABLE_LEN].act) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request capture and token injection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			op_q    <= OP_RESERVED;
			adapt_q <= 1'b0;
			nf_q    <= 1'b0;
		end else begin
			start_q <= accept && go_sweep;
			if (accept) begin
				op_q    <= s_tuser;
				adapt_q <= go_sweep && !frozen_q;
				nf_q    <= in_nf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q   <= in_sym;
			scale_q <= in_scale;
			total_q <= total_w;
		end
		if (tok_ch[TABLE_LEN].act) begin
			res_lo_q  <= lo_ch[TABLE_LEN];
			res_hi_q  <= hi_ch[TABLE_LEN];
			res_sym_q <= sym_ch[TABLE_LEN];
		end
	end

	// Freeze check on the updated total
	always_comb begin
		frozen_d = frozen_q;
		if (adapt_q) begin
			frozen_d = (CMP_W'(total_w) >= CMP_W'(limit_q)) || (total_w == '1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frozen_q <= 1'b0;
		end else if (accept && (s_tuser == OP_REINIT)) begin
			frozen_q <= 1'b0;
		end else if (out_load) begin
			frozen_q <= frozen_d;
		end
	end

	// Result fields
	always_comb begin
		o_sym   = '0;
		o_lo    = '0;
		o_hi    = '0;
		o_total = '0;
		o_nf    = 1'b0;
		unique case (op_q)
			OP_ENCODE: begin
				o_sym   = nf_q ? sym_q : res_sym_q;
				o_lo    = nf_q ? '0 : res_lo_q;
				o_hi    = nf_q ? '0 : res_hi_q;
				o_total = total_q;
				o_nf    = nf_q;
			end
			OP_DECODE: begin
				o_sym   = nf_q ? '0 : res_sym_q;
				o_lo    = nf_q ? '0 : res_lo_q;
				o_hi    = nf_q ? '0 : res_hi_q;
				o_total = total_q;
				o_nf    = nf_q;
			end
			OP_REINIT, OP_RESERVED: begin
				o_nf = 1'b0;
			end
			default: begin
				o_nf = 1'b0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= OUT_DW'({o_total, o_hi, o_lo, o_sym});
			m_tuser_q <= {frozen_d, o_nf};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Broadcast command and chain head
	assign cmd = '{decode: (op_q == OP_DECODE), adapt: adapt_q,
	               reinit: accept && (s_tuser == OP_REINIT)};
	assign tok_ch[0]  = '{act: start_q, prev_gt: 1'b0};
	assign prev_ch[0] = '0;
	assign lo_ch[0]   = '0;
	assign hi_ch[0]   = '0;
	assign sym_ch[0]  = '0;

	// Chain of count cells; the last one holds the total
	for (genvar i = 0; i < TABLE_LEN; i++) begin : g_cell
		if (i == TABLE_LEN - 1) begin : g_last
			acfm_cell #(
				.IDX(i), .COUNT_WIDTH(COUNT_WIDTH), .SYM_WIDTH(SYM_WIDTH)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .sym(sym_q), .scale(scale_q),
				.tok_in(tok_ch[i]), .prev_in(prev_ch[i]), .lo_in(lo_ch[i]),
				.hi_in(hi_ch[i]), .sym_in(sym_ch[i]),
				.tok_out(tok_ch[i+1]), .prev_out(prev_ch[i+1]), .lo_out(lo_ch[i+1]),
				.hi_out(hi_ch[i+1]), .sym_out(sym_ch[i+1]), .count(total_w)
			);
		end else begin : g_mid
			acfm_cell #(
				.IDX(i), .COUNT_WIDTH(COUNT_WIDTH), .SYM_WIDTH(SYM_WIDTH)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .sym(sym_q), .scale(scale_q),
				.tok_in(tok_ch[i]), .prev_in(prev_ch[i]), .lo_in(lo_ch[i]),
				.hi_in(hi_ch[i]), .sym_in(sym_ch[i]),
				.tok_out(tok_ch[i+1]), .prev_out(prev_ch[i+1]), .lo_out(lo_ch[i+1]),
				.hi_out(hi_ch[i+1]), .sym_out(sym_ch[i+1]), .count()
			);
		end
	end

endmodule
